/* hdl/mrhre_pkg.sv */
// Shared types and constants for the ramp engine.
package mrhre_pkg;

    typedef enum logic [1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_TICK    = 2'd2,
        KIND_READ    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PH_RISE = 2'd0,
        PH_HOLD = 2'd1,
        PH_FALL = 2'd2,
        PH_DONE = 2'd3
    } phase_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [1:0] REG_MIN_RISE = 2'd0;
    localparam logic [1:0] REG_MIN_HOLD = 2'd1;
    localparam logic [1:0] REG_MIN_FALL = 2'd2;

    localparam logic [31:0] MINUS_ONE = 32'hFFFF_0000;

    typedef struct packed {
        logic [1:0]         kind;
        logic [4:0]         channel;
        logic signed [31:0] start_level;
        logic signed [31:0] end_level;
        logic [31:0]        rise_time;
        logic [31:0]        hold_time;
        logic [31:0]        fall_time;
        logic               repeat_req;
        logic               round_trip;
        logic [15:0]        frame_time;
    } in_word_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [4:0]         channel_out;
        logic signed [31:0] level;
        logic               has_looped;
        logic [1:0]         phase_out;
    } out_word_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;      // latch input word, read channel row
        logic alloc;     // write new channel from input
        logic release_ch;
        logic step;      // take the row read from memory
        logic update;    // run the tick arithmetic on the row
        logic div_start; // start rate division when one is needed
        logic commit;    // write row back
        logic report;    // form the result word
    } cmd_t;

    typedef struct packed {
        logic    div_busy;
        logic    need_div;  // allocation or a tick phase change needs a new rate
    } sts_t;

endpackage

/* hdl/multichannel_ramp_hold_return_engine_unit.sv */
// Top level of the multichannel ramp, hold and return engine.
//
// A table of CHANNELS ramp channels in signed Q16.16. Words on the in channel
// allocate (lowest free channel), release, tick or read a channel; every word
// yields exactly one result word. One word at a time is processed: the result
// word goes through the read, exec, wait, slope, write and out states; when a
// new rate is needed (allocate, end of hold, loop restart) the slope state waits
// while the bit-serial rate divider runs its 49 steps. The next word is taken
// once the result word has been accepted.
// Channel stores sit in one single-port RAM row per channel; valid bits are
// flip-flops cleared at reset, phase bits flip-flops set to done. Config writes
// (min rise/hold/fall clamps) are taken on any cycle with cfg_we high.
module multichannel_ramp_hold_return_engine_unit
    import mrhre_pkg::*;
#(
    parameter int CHANNELS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_word_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_word_t   out_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [31:0] cfg_data
);
    cmd_t cmd;
    sts_t sts;

    mrhre_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .kind(in_data.kind),
        .sts(sts), .cmd(cmd)
    );

    mrhre_dp #(.CHANNELS(CHANNELS)) u_dp (
        .clk(clk), .rst_n(rst_n), .in_word(in_data), .cfg_we(cfg_we),
        .cfg_idx(cfg_idx), .cfg_data(cfg_data), .cmd(cmd), .sts(sts),
        .result(out_data)
    );
endmodule

/* hdl/mrhre_ram.sv */
// Generic single-port RAM with registered read.
module mrhre_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

/* hdl/mrhre_div.sv */
// Iterative rate divider: (mag << 16) / dur, one quotient bit per cycle.
module mrhre_div
    import mrhre_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [32:0] delta,
    input  logic [31:0]        dur,
    output logic               busy,
    output logic signed [31:0] rate
);
    logic [48:0] num_reg, num_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dur_reg;
    logic        neg_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [33:0] trial;
    logic [32:0] mag;
    logic [48:0] q;

    assign mag = delta[32] ? 33'(-delta) : 33'(delta);
    assign trial = {rem_reg, num_reg[48]} - {2'b0, dur_reg};
    assign q = num_next;

    always_comb
    begin
        num_next = {num_reg[47:0], 1'b0};
        rem_next = rem_reg;
        if (!trial[33])
        begin
            rem_next  = trial[32:0];
            num_next[0] = 1'b1;
        end
        else
        begin
            rem_next = {rem_reg[31:0], num_reg[48]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= (mag != '0) && (dur != '0);
            cnt_reg  <= 6'd49;
            num_reg  <= {mag, 16'b0};
            rem_reg  <= '0;
            dur_reg  <= dur;
            neg_reg  <= delta[32];
            if (mag == '0)
            begin
                rate <= '0;
            end
            else if (dur == '0)
            begin
                rate <= delta[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_reg <= 1'b0;
                if (neg_reg)
                begin
                    rate <= (q > 49'h0_8000_0000) ? 32'sh8000_0000 : 32'(-q);
                end
                else
                begin
                    rate <= (q > 49'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
                end
            end
        end
    end

    assign busy = busy_reg;
endmodule

/* hdl/mrhre_dp.sv */
// Datapath: channel tables, tick arithmetic, divider and result word.
module mrhre_dp
    import mrhre_pkg::*;
#(
    parameter int CHANNELS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  in_word_t         in_word,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_idx,
    input  logic [31:0]      cfg_data,
    input  cmd_t             cmd,
    output sts_t             sts,
    output out_word_t        result
);
    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    in_word_t             w_reg;
    logic [31:0]          min_rise_reg, min_hold_reg, min_fall_reg;
    logic [CHANNELS-1:0]  use_reg;
    logic [1:0]           ph_reg [CHANNELS];
    logic [AW:0]          used_reg;
    logic [AW-1:0]        c_reg;
    logic [1:0]           stat_reg;
    logic                 ok_reg;

    // row fields, working copies
    logic signed [31:0] lvl_reg, slp_reg, src_reg, tgt_reg;
    logic [31:0]        ht_reg, rs_reg, hs_reg, fs_reg;
    logic [2:0]         fl_reg;
    logic [1:0]         phw_reg;
    logic               div_rate_sel;

    // free search
    logic [AW-1:0] free_idx;
    logic          free_found;
    always_comb
    begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = CHANNELS - 1; i >= 0; i--)
        begin
            if (!use_reg[i])
            begin
                free_idx   = AW'(i);
                free_found = 1'b1;
            end
        end
    end

    // memory: one row holds all per-channel stores but the valid and phase bits
    localparam int RW = 32 * 8 + 3;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [RW-1:0] mem_wdata, mem_rdata;

    mrhre_ram #(.WIDTH(RW), .DEPTH(CHANNELS)) u_ram (
        .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
    );

    logic ch_ok;
    assign ch_ok = (32'(in_word.channel) < CHANNELS);
    assign mem_addr = cmd.load ? ((in_word.kind == KIND_ALLOC) ? free_idx
                                                                : in_word.channel[AW-1:0])
                               : c_reg;
    assign mem_we = cmd.commit && ok_reg;

    logic need_div_reg;

    // divider, started only when the word needs a new rate
    logic signed [32:0] d_dist;
    logic [31:0]        d_dur;
    logic signed [31:0] d_rate;
    logic               d_busy;
    mrhre_div u_div (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start && need_div_reg), .delta(d_dist),
        .dur(d_dur), .busy(d_busy), .rate(d_rate)
    );

    // tick arithmetic
    logic signed [31:0] goal;
    logic [31:0]        smag;
    logic [47:0]        prod;
    logic [31:0]        chg;
    logic signed [32:0] gap;
    logic [32:0]        dmag;
    logic               reach;
    logic signed [32:0] nl;
    logic [32:0]        hsum;
    logic [31:0]        hnew;
    assign goal = (phw_reg == PH_FALL) ? src_reg : tgt_reg;
    assign smag = slp_reg[31] ? 32'(-slp_reg) : slp_reg;
    assign prod = 48'(smag) * 48'(w_reg.frame_time);
    assign chg  = prod[47:16];
    assign gap  = 33'(goal) - 33'(lvl_reg);
    assign dmag = gap[32] ? 33'(-gap) : 33'(gap);
    assign reach = 33'(chg) >= dmag;
    assign nl = slp_reg[31] ? 33'(lvl_reg) - 33'(chg) : 33'(lvl_reg) + 33'(chg);
    assign hsum = 33'(ht_reg) + 33'(w_reg.frame_time);
    assign hnew = hsum[32] ? 32'hFFFF_FFFF : hsum[31:0];

    logic [31:0] rclamp, hclamp, fclamp;
    assign rclamp = (w_reg.rise_time > min_rise_reg) ? w_reg.rise_time : min_rise_reg;
    assign hclamp = (w_reg.hold_time > min_hold_reg) ? w_reg.hold_time : min_hold_reg;
    assign fclamp = (w_reg.fall_time > min_fall_reg) ? w_reg.fall_time : min_fall_reg;

    assign d_dist = div_rate_sel ? (33'(src_reg) - 33'(lvl_reg)) : (33'(tgt_reg) - 33'(lvl_reg));
    assign d_dur  = div_rate_sel ? fs_reg : rs_reg;

    assign sts.div_busy = d_busy;
    assign sts.need_div = need_div_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_rise_reg <= 32'd655;
            min_hold_reg <= 32'd0;
            min_fall_reg <= 32'd655;
            use_reg      <= '0;
            used_reg     <= '0;
            ok_reg       <= 1'b0;
            need_div_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                ph_reg[i] <= PH_DONE;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_MIN_RISE: min_rise_reg <= cfg_data;
                    REG_MIN_HOLD: min_hold_reg <= cfg_data;
                    REG_MIN_FALL: min_fall_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.load)
            begin
                w_reg        <= in_word;
                need_div_reg <= 1'b0;
                if (in_word.kind == KIND_ALLOC)
                begin
                    c_reg    <= free_idx;
                    ok_reg   <= free_found && (32'(used_reg) < CHANNELS);
                    stat_reg <= (free_found && (32'(used_reg) < CHANNELS)) ? ST_OK : ST_FULL;
                end
                else
                begin
                    c_reg    <= in_word.channel[AW-1:0];
                    ok_reg   <= ch_ok && use_reg[in_word.channel[AW-1:0]];
                    stat_reg <= (ch_ok && use_reg[in_word.channel[AW-1:0]]) ? ST_OK
                                                                            : ST_INVALID;
                end
            end
            if (cmd.alloc && ok_reg)
            begin
                {lvl_reg, src_reg, tgt_reg} <= {w_reg.start_level, w_reg.start_level,
                                                w_reg.end_level};
                ht_reg  <= '0;
                rs_reg  <= rclamp;
                hs_reg  <= hclamp;
                fs_reg  <= fclamp;
                fl_reg  <= {1'b0, w_reg.round_trip, w_reg.repeat_req};
                phw_reg <= PH_RISE;
                div_rate_sel <= 1'b0;
                use_reg[c_reg]  <= 1'b1;
                used_reg <= used_reg + 1'b1;
                need_div_reg <= 1'b1;
            end
            if (cmd.step)
            begin
                // row was read in the previous cycle
                {lvl_reg, slp_reg, ht_reg, src_reg, tgt_reg, rs_reg, hs_reg, fs_reg, fl_reg}
                    <= mem_rdata;
                phw_reg <= ph_reg[c_reg];
            end
            if (cmd.release_ch && ok_reg)
            begin
                use_reg[c_reg] <= 1'b0;
                ph_reg[c_reg]  <= PH_DONE;
                if (used_reg != '0)
                begin
                    used_reg <= used_reg - 1'b1;
                end
                lvl_reg <= '0;
                slp_reg <= '0;
                fl_reg  <= '0;
                phw_reg <= PH_DONE;
            end
            if (cmd.update)
            begin
                // tick arithmetic; the divider starts in S_WAIT on the new values
                if (w_reg.kind == KIND_TICK && ok_reg)
                begin
                    case (phw_reg)
                        PH_RISE:
                        begin
                            if (reach)
                            begin
                                lvl_reg <= tgt_reg;
                                ht_reg  <= '0;
                                phw_reg <= fl_reg[1] ? PH_HOLD : PH_DONE;
                            end
                            else
                            begin
                                lvl_reg <= nl[32] != nl[31] ? (nl[32] ? 32'sh8000_0000
                                                            : 32'sh7FFF_FFFF) : nl[31:0];
                            end
                        end
                        PH_HOLD:
                        begin
                            if (hnew >= hs_reg)
                            begin
                                ht_reg       <= '0;
                                phw_reg      <= PH_FALL;
                                div_rate_sel <= 1'b1;
                                need_div_reg <= 1'b1;
                            end
                            else
                            begin
                                ht_reg <= hnew;
                            end
                        end
                        PH_FALL:
                        begin
                            if (reach)
                            begin
                                lvl_reg <= src_reg;
                                if (fl_reg[0])
                                begin
                                    fl_reg[2]    <= 1'b1;
                                    phw_reg      <= PH_RISE;
                                    div_rate_sel <= 1'b0;
                                    need_div_reg <= 1'b1;
                                end
                                else
                                begin
                                    phw_reg <= PH_DONE;
                                end
                            end
                            else
                            begin
                                lvl_reg <= nl[32] != nl[31] ? (nl[32] ? 32'sh8000_0000
                                                            : 32'sh7FFF_FFFF) : nl[31:0];
                            end
                        end
                        default: ;
                    endcase
                end
            end
            if (cmd.commit)
            begin
                if (need_div_reg)
                begin
                    slp_reg <= d_rate;
                end
                if (ok_reg && w_reg.kind != KIND_READ)
                begin
                    ph_reg[c_reg] <= phw_reg;
                end
            end
        end
    end

    // row write takes the divider's slope when one ran
    logic signed [31:0] slp_out;
    assign slp_out = need_div_reg ? d_rate : slp_reg;
    assign mem_wdata = {lvl_reg, slp_out, ht_reg, src_reg, tgt_reg, rs_reg, hs_reg, fs_reg,
                        fl_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.report)
        begin
            result.status      <= stat_reg;
            result.channel_out <= (stat_reg == ST_FULL) ? 5'd0
                                : ((stat_reg == ST_INVALID) ? w_reg.channel : 5'(c_reg));
            result.level       <= ok_reg ? lvl_reg : MINUS_ONE;
            result.has_looped  <= ok_reg ? fl_reg[2] : 1'b0;
            result.phase_out   <= ok_reg ? phw_reg : PH_DONE;
        end
    end
endmodule

/* hdl/mrhre_ctrl.sv */
// Controller: sequences load, update, divide, write back and report.
module mrhre_ctrl
    import mrhre_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  logic [1:0] kind,
    input  sts_t  sts,
    output cmd_t  cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EXEC, S_WAIT, S_SLOPE, S_WRITE, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;
    logic [1:0] kind_reg;

    assign in_ready  = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid = ov_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        ov_next    = ov_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                case (kind_reg)
                    KIND_ALLOC:   cmd.alloc = 1'b1;
                    KIND_RELEASE: cmd.release_ch = 1'b1;
                    default:      cmd.step = 1'b1;
                endcase
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.update = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_SLOPE;
            end
            S_SLOPE:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.commit = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.report = 1'b1;
                ov_next    = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            kind_reg  <= KIND_READ;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            if (cmd.load)
            begin
                kind_reg <= kind;
            end
        end
    end
endmodule
